FILE: src/bnfa_pkg.sv
// Package for the bitmap next-fit slot allocator.
// Widths, codes, payload types and controller/datapath link structs.
// No dependencies.
`timescale 1ns / 1ps

package bnfa_pkg;

  // Built depth of the used map and derived widths
  localparam int MAX_SLOTS = 256;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = SLOT_W + 1;
  localparam int MOD_CNT_W = (SLOT_W > 1) ? $clog2(SLOT_W) : 1;

  // Scan group: slots examined per search cycle
  localparam int GRP   = 16;
  localparam int GRP_W = $clog2(GRP);

  // Field widths
  localparam int CMD_W    = 1;
  localparam int IN_SLOT_W = 8;
  localparam int STATUS_W = 3;
  localparam int ADDR_W   = 28;
  localparam int NUM_W    = 9;
  localparam int SIZE_W   = 21;
  localparam int OFFS_W   = 20;
  localparam int PROD_W   = SLOT_W + SIZE_W;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;

  localparam logic [NUM_W-1:0]  RST_NUM_SLOTS   = NUM_W'(256);
  localparam logic [SIZE_W-1:0] RST_SLOT_BYTES  = SIZE_W'(4096);
  localparam logic [OFFS_W-1:0] RST_BASE_OFFSET = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLED     = 2'd0,
    CFG_NUM_SLOTS   = 2'd1,
    CFG_SLOT_BYTES  = 2'd2,
    CFG_BASE_OFFSET = 2'd3
  } cfg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_DISABLED = 3'd1,
    ST_FULL     = 3'd2,
    ST_WAS_FREE = 3'd3,
    ST_INVALID  = 3'd4
  } status_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MODULO,
    S_SCAN,
    S_MULT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [IN_SLOT_W-1:0] slot;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [IN_SLOT_W-1:0] granted_slot;
    logic [ADDR_W-1:0]    slot_address;
    logic [SIZE_W-1:0]    block_size;
  } out_t;

  typedef struct packed {
    logic              enabled;
    logic [NUM_W-1:0]  num_slots;
    logic [SIZE_W-1:0] slot_bytes;
    logic [OFFS_W-1:0] base_offset;
  } cfg_t;

  // Controller -> datapath
  typedef struct packed {
    logic accept;
    logic mod_step;
    logic scan_step;
    logic mult;
    logic finish;
  } ctrl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic is_free;
    logic enabled;
    logic cnt_zero;
    logic stale;
    logic mod_last;
    logic found;
    logic exhausted;
    logic out_room;
  } dp_stat_t;

endpackage

FILE: src/bnfa_cfg.sv
// Configuration register file for the slot allocator.
// Depends on bnfa_pkg.
`timescale 1ns / 1ps

module bnfa_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bnfa_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [bnfa_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output bnfa_pkg::cfg_t                cfg
);
  import bnfa_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled     <= 1'b1;
      cfg_r.num_slots   <= RST_NUM_SLOTS;
      cfg_r.slot_bytes  <= RST_SLOT_BYTES;
      cfg_r.base_offset <= RST_BASE_OFFSET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_ENABLED:     cfg_r.enabled     <= cfg_wdata[0];
        CFG_NUM_SLOTS:   cfg_r.num_slots   <= cfg_wdata[NUM_W-1:0];
        CFG_SLOT_BYTES:  cfg_r.slot_bytes  <= cfg_wdata[SIZE_W-1:0];
        CFG_BASE_OFFSET: cfg_r.base_offset <= cfg_wdata[OFFS_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: src/bnfa_ctrl.sv
// Controller state machine for the slot allocator.
// Sequences accept, pointer reduction, group scan, address multiply and result load.
// Depends on bnfa_pkg.
`timescale 1ns / 1ps

module bnfa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bnfa_pkg::dp_stat_t   stat,
  output bnfa_pkg::ctrl_cmd_t  cmd
);
  import bnfa_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (stat.is_free || !stat.enabled || stat.cnt_zero) begin
            state_nxt = S_FINISH;
          end else if (stat.stale) begin
            state_nxt = S_MODULO;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_MODULO: begin
        if (stat.mod_last) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (stat.found) begin
          state_nxt = S_MULT;
        end else if (stat.exhausted) begin
          state_nxt = S_FINISH;
        end
      end
      S_MULT:   state_nxt = S_FINISH;
      S_FINISH: begin
        if (stat.out_room) state_nxt = S_IDLE;
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = (state_r != S_IDLE);
    cmd.accept    = (state_r == S_IDLE) && in_valid;
    cmd.mod_step  = (state_r == S_MODULO);
    cmd.scan_step = (state_r == S_SCAN);
    cmd.mult      = (state_r == S_MULT);
    cmd.finish    = (state_r == S_FINISH) && stat.out_room;
  end

endmodule

FILE: src/bnfa_dp.sv
// Datapath for the slot allocator: used map, next-fit pointer, pointer
// modulo unit, group scan, address multiply and output register.
// Depends on bnfa_pkg.
`timescale 1ns / 1ps

module bnfa_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bnfa_pkg::cfg_t       cfg,
  input  bnfa_pkg::in_t        in_data,
  input  bnfa_pkg::ctrl_cmd_t  cmd,
  output bnfa_pkg::dp_stat_t   stat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bnfa_pkg::out_t       out_data
);
  import bnfa_pkg::*;

  logic [MAX_SLOTS-1:0] used_r;
  logic [SLOT_W-1:0]    search_start_r;

  logic [SLOT_W-1:0]    mshift_r;
  logic [SLOT_W-1:0]    rem_r;
  logic [MOD_CNT_W-1:0] mod_cnt_r;

  logic [CNT_W-1:0]     cursor_r;
  logic [CNT_W-1:0]     start_r;
  logic [CNT_W-1:0]     limit_r;
  logic                 phase_r;

  status_t              status_r;
  logic                 grant_r;
  logic [SLOT_W-1:0]    gslot_r;
  logic [PROD_W-1:0]    prod_r;

  logic                 out_valid_r;
  out_t                 out_r;

  logic [CNT_W-1:0]     n_live;
  logic [SLOT_W-1:0]    free_idx;
  logic                 free_range_bad;
  logic [CNT_W-1:0]     mod_t;
  logic [SLOT_W-1:0]    rem_nxt;

  logic [CNT_W-1:0]     grp_base;
  logic [GRP-1:0]       cand;
  logic [GRP_W-1:0]     hit;
  logic [SLOT_W-1:0]    found_idx;
  logic [CNT_W-1:0]     cursor_nxt;
  logic [CNT_W-1:0]     idx_inc;
  logic [ADDR_W-1:0]    addr_sum;

  // Slot count in effect is capped at the built depth
  assign n_live = (32'(cfg.num_slots) > 32'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                         : CNT_W'(cfg.num_slots);

  assign free_idx       = SLOT_W'(in_data.slot);
  assign free_range_bad = (32'(in_data.slot) >= 32'(n_live));

  // One quotient bit per cycle: remainder of the stale pointer by the count
  assign mod_t   = {rem_r, mshift_r[SLOT_W-1]};
  assign rem_nxt = (mod_t >= n_live) ? SLOT_W'(mod_t - n_live) : SLOT_W'(mod_t);

  // Group scan: free slots in [cursor, limit) inside the cursor's group
  assign grp_base = {cursor_r[CNT_W-1:GRP_W], {GRP_W{1'b0}}};

  always_comb begin
    logic [CNT_W-1:0] idx_c;
    for (int j = 0; j < GRP; j++) begin
      idx_c   = grp_base + CNT_W'(j);
      cand[j] = (idx_c >= cursor_r) && (idx_c < limit_r) && !used_r[SLOT_W'(idx_c)];
    end
  end

  always_comb begin
    hit = '0;
    for (int j = GRP - 1; j >= 0; j--) begin
      if (cand[j]) hit = GRP_W'(j);
    end
  end

  assign found_idx  = SLOT_W'(grp_base + CNT_W'(hit));
  assign cursor_nxt = grp_base + CNT_W'(GRP);
  assign idx_inc    = CNT_W'(found_idx) + CNT_W'(1);
  assign addr_sum   = ADDR_W'(prod_r) + ADDR_W'(cfg.base_offset);

  always_comb begin
    stat.is_free   = (in_data.cmd == CMD_FREE);
    stat.enabled   = cfg.enabled;
    stat.cnt_zero  = (n_live == '0);
    stat.stale     = ({1'b0, search_start_r} >= n_live);
    stat.mod_last  = (mod_cnt_r == MOD_CNT_W'(SLOT_W - 1));
    stat.found     = |cand;
    stat.exhausted = !(|cand) && (cursor_nxt >= limit_r) && phase_r;
    stat.out_room  = !out_valid_r || !out_stall;
  end

  // Control state: used map, pointer, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r         <= '0;
      search_start_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cmd.accept && stat.is_free && !free_range_bad) begin
        used_r[free_idx] <= 1'b0;
      end
      if (cmd.scan_step && stat.found) begin
        used_r[found_idx] <= 1'b1;
        search_start_r    <= (idx_inc == n_live) ? '0 : SLOT_W'(idx_inc);
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers of the current command
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      grant_r   <= 1'b0;
      mshift_r  <= search_start_r;
      rem_r     <= '0;
      mod_cnt_r <= '0;
      cursor_r  <= {1'b0, search_start_r};
      start_r   <= {1'b0, search_start_r};
      limit_r   <= n_live;
      phase_r   <= 1'b0;
      if (stat.is_free) begin
        if (free_range_bad) begin
          status_r <= ST_INVALID;
        end else if (!used_r[free_idx]) begin
          status_r <= ST_WAS_FREE;
        end else begin
          status_r <= ST_OK;
        end
      end else begin
        status_r <= cfg.enabled ? ST_FULL : ST_DISABLED;
      end
    end

    if (cmd.mod_step) begin
      rem_r     <= rem_nxt;
      mshift_r  <= {mshift_r[SLOT_W-2:0], 1'b0};
      mod_cnt_r <= mod_cnt_r + MOD_CNT_W'(1);
      if (stat.mod_last) begin
        cursor_r <= {1'b0, rem_nxt};
        start_r  <= {1'b0, rem_nxt};
      end
    end

    if (cmd.scan_step) begin
      if (stat.found) begin
        gslot_r  <= found_idx;
        grant_r  <= 1'b1;
        status_r <= ST_OK;
      end else if (cursor_nxt >= limit_r) begin
        // first pass done: wrap to the slots below the start point
        phase_r  <= 1'b1;
        cursor_r <= '0;
        limit_r  <= start_r;
      end else begin
        cursor_r <= cursor_nxt;
      end
    end

    if (cmd.mult) begin
      prod_r <= PROD_W'(gslot_r) * PROD_W'(cfg.slot_bytes);
    end

    if (cmd.finish) begin
      out_r.status <= status_r;
      if (grant_r) begin
        out_r.granted_slot <= IN_SLOT_W'(gslot_r);
        out_r.slot_address <= addr_sum;
        out_r.block_size   <= cfg.slot_bytes;
      end else begin
        out_r.granted_slot <= '0;
        out_r.slot_address <= '0;
        out_r.block_size   <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: src/bitmap_next_fit_slot_allocator.sv
// Top level of the bitmap next-fit slot allocator.
// Instantiates bnfa_cfg, bnfa_ctrl and bnfa_dp; depends on bnfa_pkg.
//
//   channel  ports                           direction  transfer when
//   in       in_valid, in_stall, in_data     input      in_valid && !in_stall
//   out      out_valid, out_stall, out_data  output     out_valid && !out_stall
//   cfg      cfg_we, cfg_idx, cfg_wdata      input      cfg_we
//
// One command at a time. Free, disabled and zero-count allocate go from accept
// straight to the result load. Allocate: accept, then the group scan (16 slots
// per cycle), then a multiply when a slot is granted, then the result load; a
// pointer left beyond a lowered count adds a bit-serial remainder before the
// scan. Synchronous active-low reset clears the used map and the pointer. A stalled
// result holds in the output register while the next command is accepted; the
// next result load waits until that register drains.
`timescale 1ns / 1ps

module bitmap_next_fit_slot_allocator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  bnfa_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output bnfa_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [bnfa_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [bnfa_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bnfa_pkg::*;

  cfg_t      cfg;
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  bnfa_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bnfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bnfa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for bitmap_next_fit_slot_allocator.
// Directed table, then random allocate/free traffic checked against a local predictor.
// Depends on bnfa_pkg and the allocator RTL.
`timescale 1ns / 1ps

module testbench;
  import bnfa_pkg::*;

  localparam int QUIET_LIMIT = 4000;  // cycles with no transfer before giving up
  localparam int SETTLE      = 40;    // worst allocate latency plus margin
  localparam int N_DIR       = 25;

  typedef struct packed {
    logic                  is_cfg;
    cfg_idx_t              reg_sel;
    logic [CFG_DATA_W-1:0] reg_val;
    cmd_t                  cmd;
    logic [IN_SLOT_W-1:0]  slot;
    logic                  typed;   // res holds the known answer
    out_t                  res;
  } dir_row_t;

  // Reset state: enabled, 256 slots of 4096 bytes, offset 0, pointer 0.
  localparam dir_row_t DIR_TBL [N_DIR] = '{
    '{1'b0, CFG_ENABLED, '0, CMD_FREE, 8'd0, 1'b1, '{ST_WAS_FREE, 8'd0, 28'd0, 21'd0}},
    '{1'b0, CFG_ENABLED, '0, CMD_FREE, 8'd255, 1'b1, '{ST_WAS_FREE, 8'd0, 28'd0, 21'd0}},
    '{1'b0, CFG_ENABLED, '0, CMD_ALLOC, 8'd255, 1'b1, '{ST_OK, 8'd0, 28'd0, 21'd4096}},
    '{1'b0, CFG_ENABLED, '0, CMD_ALLOC, 8'd0, 1'b1, '{ST_OK, 8'd1, 28'd4096, 21'd4096}},
    '{1'b0, CFG_ENABLED, '0, CMD_FREE, 8'd0, 1'b1, '{ST_OK, 8'd0, 28'd0, 21'd0}},
    // pointer now sits past the lowered count
    '{1'b1, CFG_NUM_SLOTS, 21'd2, CMD_ALLOC, 8'd0, 1'b0, '0},
    '{1'b0, CFG_ENABLED, '0, CMD_ALLOC, 8'h55, 1'b1, '{ST_OK, 8'd0, 28'd0, 21'd4096}},
    '{1'b0, CFG_ENABLED, '0, CMD_ALLOC, 8'hAA, 1'b1, '{ST_FULL, 8'd0, 28'd0, 21'd0}},
    '{1'b1, CFG_ENABLED, 21'd0, CMD_ALLOC, 8'd0, 1'b0, '0},
    // disabled wins over full; free still works
    '{1'b0, CFG_ENABLED, '0, CMD_ALLOC, 8'd0, 1'b1, '{ST_DISABLED, 8'd0, 28'd0, 21'd0}},
    '{1'b0, CFG_ENABLED, '0, CMD_FREE, 8'd1, 1'b1, '{ST_OK, 8'd0, 28'd0, 21'd0}},
    '{1'b0, CFG_ENABLED, '0, CMD_FREE, 8'd2, 1'b1, '{ST_INVALID, 8'd0, 28'd0, 21'd0}},
    '{1'b1, CFG_ENABLED, 21'd1, CMD_ALLOC, 8'd0, 1'b0, '0},
    '{1'b1, CFG_NUM_SLOTS, 21'd0, CMD_ALLOC, 8'd0, 1'b0, '0},
    '{1'b0, CFG_ENABLED, '0, CMD_ALLOC, 8'd0, 1'b1, '{ST_FULL, 8'd0, 28'd0, 21'd0}},
    '{1'b0, CFG_ENABLED, '0, CMD_FREE, 8'd0, 1'b1, '{ST_INVALID, 8'd0, 28'd0, 21'd0}},
    // count above the built depth clamps to 256
    '{1'b1, CFG_NUM_SLOTS, 21'd511, CMD_ALLOC, 8'd0, 1'b0, '0},
    '{1'b1, CFG_SLOT_BYTES, 21'd1048576, CMD_ALLOC, 8'd0, 1'b0, '0},
    '{1'b1, CFG_BASE_OFFSET, 21'd1048575, CMD_ALLOC, 8'd0, 1'b0, '0},
    '{1'b0, CFG_ENABLED, '0, CMD_ALLOC, 8'hFF, 1'b0, '0},
    '{1'b0, CFG_ENABLED, '0, CMD_FREE, 8'd255, 1'b1, '{ST_WAS_FREE, 8'd0, 28'd0, 21'd0}},
    // slot 0 kept its used bit while the count was 0
    '{1'b0, CFG_ENABLED, '0, CMD_FREE, 8'd0, 1'b1, '{ST_OK, 8'd0, 28'd0, 21'd0}},
    '{1'b1, CFG_SLOT_BYTES, 21'd0, CMD_ALLOC, 8'd0, 1'b0, '0},
    '{1'b0, CFG_ENABLED, '0, CMD_ALLOC, 8'd0, 1'b0, '0},
    '{1'b0, CFG_ENABLED, '0, CMD_FREE, 8'd2, 1'b0, '0}
  };

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor state
  logic                  slot_used [MAX_SLOTS];
  logic [SLOT_W-1:0]     next_ptr;
  logic                  cfg_en;
  logic [NUM_W-1:0]      cfg_count;
  logic [SIZE_W-1:0]     cfg_size;
  logic [OFFS_W-1:0]     cfg_base;

  out_t pending_res [$];
  out_t want;
  int   in_idle      = 31;
  int   out_idle     = 71;
  int   n_fail       = 0;
  int   n_items      = 0;
  int   n_results    = 0;
  int   status_seen [5];
  int   quiet_cycles = 0;

  bitmap_next_fit_slot_allocator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int live_slots();
    return (cfg_count > MAX_SLOTS) ? MAX_SLOTS : int'(cfg_count);
  endfunction

  // Next-fit search or free on the local bitmap; returns the expected result.
  function automatic out_t apply_cmd(in_t item);
    out_t r;
    int   lim;
    int   idx;
    int   k;
    bit   found;
    r     = '0;
    found = 1'b0;
    lim   = live_slots();
    if (item.cmd == CMD_ALLOC) begin
      if (!cfg_en) begin
        r.status = ST_DISABLED;
      end else begin
        r.status = ST_FULL;
        for (k = 0; k < lim && !found; k++) begin
          idx = (int'(next_ptr) % lim + k) % lim;
          if (!slot_used[idx]) begin
            found          = 1'b1;
            slot_used[idx] = 1'b1;
            next_ptr       = (idx + 1 == lim) ? '0 : SLOT_W'(idx + 1);
            r.status       = ST_OK;
            r.granted_slot = IN_SLOT_W'(idx);
            r.slot_address = ADDR_W'(longint'(cfg_base) + longint'(idx) * longint'(cfg_size));
            r.block_size   = cfg_size;
          end
        end
      end
    end else begin
      if (int'(item.slot) >= lim) begin
        r.status = ST_INVALID;
      end else if (!slot_used[item.slot]) begin
        r.status = ST_WAS_FREE;
      end else begin
        slot_used[item.slot] = 1'b0;
        r.status             = ST_OK;
      end
    end
    return r;
  endfunction

  // A slot that is currently allocated and in range, else any slot.
  function automatic logic [IN_SLOT_W-1:0] pick_used();
    int first;
    int idx;
    int lim;
    first = $urandom_range(MAX_SLOTS - 1);
    lim   = live_slots();
    for (int k = 0; k < MAX_SLOTS; k++) begin
      idx = (first + k) % MAX_SLOTS;
      if (idx < lim && slot_used[idx]) return IN_SLOT_W'(idx);
    end
    return IN_SLOT_W'($urandom_range(255));
  endfunction

  // Called at a clock edge; returns at the edge where the command transfers.
  task automatic send(cmd_t c, logic [IN_SLOT_W-1:0] s, logic typed, out_t known);
    in_t item;
    out_t pred;
    while ($urandom_range(99) < in_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    item.cmd  = c;
    item.slot = s;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    pred = apply_cmd(item);
    pending_res.push_back(typed ? known : pred);
    n_items++;
  endtask

  // Hold off the sender until every outstanding result has come back.
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t sel, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= sel;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (sel)
      CFG_ENABLED:     cfg_en    = val[0];
      CFG_NUM_SLOTS:   cfg_count = val[NUM_W-1:0];
      CFG_SLOT_BYTES:  cfg_size  = val[SIZE_W-1:0];
      CFG_BASE_OFFSET: cfg_base  = val[OFFS_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic run_phase(int i_idle, int o_idle, logic en, logic [NUM_W-1:0] cnt,
                           logic [SIZE_W-1:0] sz, logic [OFFS_W-1:0] offs,
                           int count, int alloc_pct);
    int r;
    quiesce();
    in_idle  = i_idle;
    out_idle = o_idle;
    cfg_write(CFG_ENABLED, CFG_DATA_W'(en));
    cfg_write(CFG_NUM_SLOTS, CFG_DATA_W'(cnt));
    cfg_write(CFG_SLOT_BYTES, CFG_DATA_W'(sz));
    cfg_write(CFG_BASE_OFFSET, CFG_DATA_W'(offs));
    repeat (count) begin
      r = $urandom_range(99);
      if (r < alloc_pct)
        send(CMD_ALLOC, IN_SLOT_W'($urandom_range(255)), 1'b0, '0);
      else if (r < alloc_pct + (100 - alloc_pct) * 3 / 4)
        send(CMD_FREE, pick_used(), 1'b0, '0);
      else
        send(CMD_FREE, IN_SLOT_W'($urandom_range(255)), 1'b0, '0);
    end
  endtask

  // receiver backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < out_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (pending_res.size() == 0) begin
        $error("result transfer with nothing pending: status %0d slot %0d",
               out_data.status, out_data.granted_slot);
        n_fail++;
      end else begin
        want = pending_res.pop_front();
        if (want.status < 5) status_seen[want.status]++;
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          n_fail++;
        end
        if (out_data.granted_slot !== want.granted_slot) begin
          $error("granted_slot: expected %0d, got %0d", want.granted_slot,
                 out_data.granted_slot);
          n_fail++;
        end
        if (out_data.slot_address !== want.slot_address) begin
          $error("slot_address: expected 0x%0h, got 0x%0h", want.slot_address,
                 out_data.slot_address);
          n_fail++;
        end
        if (out_data.block_size !== want.block_size) begin
          $error("block_size: expected %0d, got %0d", want.block_size,
                 out_data.block_size);
          n_fail++;
        end
      end
    end
  end

  // watchdog: no transfer on either channel for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < MAX_SLOTS; i++) slot_used[i] = 1'b0;
    for (int i = 0; i < 5; i++) status_seen[i] = 0;
    next_ptr  = '0;
    cfg_en    = 1'b1;
    cfg_count = RST_NUM_SLOTS;
    cfg_size  = RST_SLOT_BYTES;
    cfg_base  = RST_BASE_OFFSET;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      if (DIR_TBL[i].is_cfg) begin
        quiesce();
        cfg_write(DIR_TBL[i].reg_sel, DIR_TBL[i].reg_val);
      end else begin
        send(DIR_TBL[i].cmd, DIR_TBL[i].slot, DIR_TBL[i].typed, DIR_TBL[i].res);
      end
    end

    // largest size and offset with allocate-heavy traffic: addresses wrap
    run_phase(31, 71, 1'b1, 9'd256, 21'h1FFFFF, 20'hFFFFF, 170, 90);
    run_phase(31, 71, 1'b1, NUM_W'($urandom_range(1, 16)), SIZE_W'($urandom),
              OFFS_W'($urandom), 90, 50);
    run_phase(71, 31, 1'b1, 9'd1, 21'd1, 20'd0, 40, 50);
    run_phase(71, 31, 1'b0, 9'd511, SIZE_W'($urandom), OFFS_W'($urandom), 40, 40);
    // lowered count leaves the pointer and used bits beyond it
    run_phase(0, 0, 1'b1, NUM_W'($urandom_range(2, 40)), SIZE_W'($urandom),
              OFFS_W'($urandom), 120, 55);
    run_phase(0, 0, 1'b1, 9'd300, 21'd4096, 20'd0, 150, 50);
    run_phase(0, 0, 1'b1, 9'd0, SIZE_W'($urandom), OFFS_W'($urandom), 20, 50);

    quiesce();
    repeat (SETTLE) @(posedge clk);

    $display("ran %0d commands, %0d results over slot counts 0, 1, small, 256 and clamped",
             n_items, n_results);
    $display("results: ok %0d, disabled %0d, full %0d, already free %0d, invalid %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4]);
    if (n_fail == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
